// ===== design/motion_command_frame_builder_top_defines.svh =====
// assertion macros shared by the checker
`ifndef MOTION_COMMAND_FRAME_BUILDER_TOP_DEFINES_SVH
`define MOTION_COMMAND_FRAME_BUILDER_TOP_DEFINES_SVH

// implication in the same cycle, off while reset is low
`define MCFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle, off while reset is low
`define MCFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// implication checked in the next cycle, also checked through reset
`define MCFB_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mcfb_pkg.sv =====
`default_nettype none

package mcfb_pkg;

    localparam int BYTE_W      = 8;
    localparam int S_TDATA_W   = 80;
    localparam int ADDR_W      = 8;

    localparam int SPEED_BODY  = 13;
    localparam int POS_BODY    = 17;
    localparam int POS_LEN     = 19;
    localparam int CNT_W       = $clog2(POS_LEN);
    localparam int IMAGE_W     = POS_BODY * BYTE_W;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] REG_HI         = 8'h00;
    localparam logic [7:0] REG_SPEED      = 8'hF6;
    localparam logic [7:0] REG_POS        = 8'hFD;
    localparam logic [7:0] NREG_HI        = 8'h00;
    localparam logic [7:0] NREG_SPEED     = 8'h03;
    localparam logic [7:0] NREG_POS       = 8'h05;
    localparam logic [7:0] NBYTES_SPEED   = 8'h06;
    localparam logic [7:0] NBYTES_POS     = 8'h0A;
    localparam logic [7:0] PAD_BYTE       = 8'h00;

    localparam logic [7:0] MODE_REL       = 8'h00;
    localparam logic [7:0] MODE_ABS       = 8'h01;

    localparam logic       FUNC_SPEED     = 1'b0;
    localparam logic       FUNC_POS       = 1'b1;

    typedef struct packed {
        logic load;
        logic shift;
    } t_sr_ctrl;

    typedef struct packed {
        logic clear;
        logic update;
    } t_crc_ctrl;

endpackage

`default_nettype wire

// ===== design/motion_command_frame_builder_top.sv =====
// channel     dir   handshake                          payload
// command     in    i_s_axis_tvalid / o_s_axis_tready  i_s_axis_tdata, i_s_axis_tuser
// frame byte  out   o_m_axis_tvalid / i_m_axis_tready  o_m_axis_tdata, o_m_axis_tlast,
//                                                      o_m_axis_tuser
// config      in    i_cfg_we                           i_cfg_wdata
//
// one frame byte per cycle, while the output is not stalled, from a byte shift line
// and a byte-serial crc register; a command is loaded, then sent beat by beat as a speed
// frame, a position frame or, for a bad mode, a lone error beat
// the next command is taken the cycle after the last beat enters the output register
// synchronous active-low reset; slave address resets to 1
// a stalled output holds the byte stream, nothing is dropped
`default_nettype none

module motion_command_frame_builder_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mcfb_pkg::ADDR_W-1:0]     i_cfg_wdata,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // direction[7:0] accel[15:8] speed_rpm[31:16] pulse_count[63:32]
    // move_mode[71:64] sync_flag[79:72]
    input  wire logic [mcfb_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // func[0]
    input  wire logic                            i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // frame_byte[7:0]
    output logic      [mcfb_pkg::BYTE_W-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tlast,
    // error[0]
    output logic                                 o_m_axis_tuser
);
    import mcfb_pkg::*;

    logic [ADDR_W-1:0] r_slave_addr;
    logic              r_busy;
    logic              n_busy;
    logic              r_err;
    logic              n_err;
    logic              r_pos;
    logic              n_pos;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_m_valid;
    logic              n_m_valid;
    logic [BYTE_W-1:0] r_m_data;
    logic [BYTE_W-1:0] n_m_data;
    logic              r_m_last;
    logic              n_m_last;
    logic              r_m_err;
    logic              n_m_err;

    logic              accept;
    logic              adv;
    logic              mode_bad;
    logic [CNT_W-1:0]  body_len;
    logic [IMAGE_W-1:0] image;
    logic [BYTE_W-1:0] sr_byte;
    logic [15:0]       crc;
    t_sr_ctrl          sr_ctrl;
    t_crc_ctrl         crc_ctrl;

    logic [7:0] f_dir;
    logic [7:0] f_acc;
    logic [15:0] f_spd;
    logic [31:0] f_pulse;
    logic [7:0] f_mode;
    logic [7:0] f_sync;

    assign f_dir   = i_s_axis_tdata[7:0];
    assign f_acc   = i_s_axis_tdata[15:8];
    assign f_spd   = i_s_axis_tdata[31:16];
    assign f_pulse = i_s_axis_tdata[63:32];
    assign f_mode  = i_s_axis_tdata[71:64];
    assign f_sync  = i_s_axis_tdata[79:72];

    assign accept   = i_s_axis_tvalid && !r_busy;
    assign adv      = r_busy && (!r_m_valid || i_m_axis_tready);
    assign mode_bad = (i_s_axis_tuser == FUNC_POS) && (f_mode != MODE_REL)
                      && (f_mode != MODE_ABS);
    assign body_len = r_pos ? CNT_W'(POS_BODY) : CNT_W'(SPEED_BODY);

    // frame body, first byte in the low bits
    always_comb begin
        if (i_s_axis_tuser == FUNC_POS) begin
            image = {f_sync, f_mode, f_pulse[7:0], f_pulse[15:8], f_pulse[23:16],
                     f_pulse[31:24], f_spd[7:0], f_spd[15:8], f_acc, f_dir,
                     NBYTES_POS, NREG_POS, NREG_HI, REG_POS, REG_HI,
                     FC_WRITE_MULTI, r_slave_addr};
        end else begin
            image = {{4{PAD_BYTE}}, PAD_BYTE, f_sync, f_spd[7:0], f_spd[15:8],
                     f_acc, f_dir, NBYTES_SPEED, NREG_SPEED, NREG_HI, REG_SPEED,
                     REG_HI, FC_WRITE_MULTI, r_slave_addr};
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_err     = r_err;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        n_m_err   = r_m_err;
        sr_ctrl   = '0;
        crc_ctrl  = '0;
        if (accept) begin
            n_busy         = 1'b1;
            n_err          = mode_bad;
            n_pos          = i_s_axis_tuser;
            n_cnt          = '0;
            sr_ctrl.load   = 1'b1;
            crc_ctrl.clear = 1'b1;
        end else if (adv) begin
            n_m_valid = 1'b1;
            n_m_last  = 1'b0;
            n_m_err   = 1'b0;
            if (r_err) begin
                n_m_data = '0;
                n_m_last = 1'b1;
                n_m_err  = 1'b1;
                n_busy   = 1'b0;
            end else if (r_cnt < body_len) begin
                n_m_data        = sr_byte;
                sr_ctrl.shift   = 1'b1;
                crc_ctrl.update = 1'b1;
                n_cnt           = r_cnt + 1'b1;
            end else if (r_cnt == body_len) begin
                n_m_data = crc[7:0];
                n_cnt    = r_cnt + 1'b1;
            end else begin
                n_m_data = crc[15:8];
                n_m_last = 1'b1;
                n_busy   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= ADDR_W'(1);
            r_busy       <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slave_addr <= i_cfg_wdata;
            end
            r_busy    <= n_busy;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err    <= n_err;
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        r_m_err  <= n_m_err;
    end

    mcfb_frame_sr u_sr (
        .i_clk   (i_clk),
        .i_ctrl  (sr_ctrl),
        .i_image (image),
        .o_byte  (sr_byte)
    );

    mcfb_crc u_crc (
        .i_clk  (i_clk),
        .i_ctrl (crc_ctrl),
        .i_byte (sr_byte),
        .o_crc  (crc)
    );

    assign o_s_axis_tready = !r_busy;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tuser  = r_m_err;

endmodule

`default_nettype wire

// ===== design/mcfb_frame_sr.sv =====
`default_nettype none

module mcfb_frame_sr (
    input  wire logic                          i_clk,
    input  wire mcfb_pkg::t_sr_ctrl            i_ctrl,
    input  wire logic [mcfb_pkg::IMAGE_W-1:0]  i_image,
    output logic      [mcfb_pkg::BYTE_W-1:0]   o_byte
);
    import mcfb_pkg::*;

    logic [IMAGE_W-1:0] r_sr;
    logic [IMAGE_W-1:0] n_sr;

    // byte-wide shift line, frame byte zero sits in the low bits
    always_comb begin
        n_sr = r_sr;
        if (i_ctrl.load) begin
            n_sr = i_image;
        end else if (i_ctrl.shift) begin
            n_sr = {{BYTE_W{1'b0}}, r_sr[IMAGE_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr <= n_sr;
    end

    assign o_byte = r_sr[BYTE_W-1:0];

endmodule

`default_nettype wire

// ===== design/mcfb_crc.sv =====
`default_nettype none

module mcfb_crc (
    input  wire logic                        i_clk,
    input  wire mcfb_pkg::t_crc_ctrl         i_ctrl,
    input  wire logic [mcfb_pkg::BYTE_W-1:0] i_byte,
    output logic      [15:0]                 o_crc
);
    import mcfb_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] step;

    // one byte per cycle while update is set, eight reflected shift steps
    always_comb begin
        step = r_crc ^ {8'h00, i_byte};
        for (int k = 0; k < BYTE_W; k++) begin
            if (step[0]) begin
                step = {1'b0, step[15:1]} ^ CRC_POLY;
            end else begin
                step = {1'b0, step[15:1]};
            end
        end
        n_crc = r_crc;
        if (i_ctrl.clear) begin
            n_crc = CRC_INIT;
        end else if (i_ctrl.update) begin
            n_crc = step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

// ===== design/mcfb_checker.sv =====
`default_nettype none
`include "motion_command_frame_builder_top_defines.svh"

module mcfb_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    input  wire logic                            o_s_axis_tready,
    input  wire logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic [mcfb_pkg::BYTE_W-1:0]     o_m_axis_tdata,
    input  wire logic                            o_m_axis_tlast,
    input  wire logic                            o_m_axis_tuser
);
    import mcfb_pkg::*;

    // a stalled output beat holds
    `MCFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output beat changed under stall")

    // an error beat is a lone zero beat closing the frame
    `MCFB_ASSERT_NOW(a_err_beat, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast && (o_m_axis_tdata == '0), "error beat not a zero last beat")

    // an accepted command blocks the input until its last beat enters the output register
    `MCFB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input ready right after a command")

    // nothing is offered right after reset
    `MCFB_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready, "outputs not idle after reset")

endmodule

bind motion_command_frame_builder_top mcfb_checker u_mcfb_checker (.*);

`default_nettype wire
